// ===== rtl/core/magic_length_frame_deframer_top_assert.svh =====
// assertion macros used by the deframer checker
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define MLFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mlfd assertion failed");

// next-cycle implication
`define MLFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mlfd assertion failed");

`endif

// ===== rtl/core/mlfd_pkg.sv =====
// types and constants of the magic/length frame deframer
`default_nettype none
package mlfd_pkg;

	localparam logic [7:0]  MAGIC_FIRST    = 8'h54;
	localparam logic [7:0]  MAGIC_SECOND   = 8'h43;
	localparam logic [31:0] MAX_BODY_RESET = 32'd65536;
	localparam int          HDR_BYTES      = 8;
	localparam int          HDR_CNT_W      = $clog2(HDR_BYTES);

	typedef enum logic [1:0] {
		EV_PAYLOAD   = 2'd0,
		EV_MISMATCH  = 2'd1,
		EV_TOO_LARGE = 2'd2,
		EV_EMPTY     = 2'd3
	} event_kind_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_BODY   = 3'b010,
		PH_CLOSED = 3'b100
	} phase_t;

endpackage
`default_nettype wire

// ===== rtl/core/mlfd_rx_if.sv =====
// received byte channel
`default_nettype none
interface mlfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mlfd_evt_if.sv =====
// deframer event channel
`default_nettype none
interface mlfd_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [7:0] payload_byte;
	logic       frame_last;

	modport source (output valid, output event_kind, output payload_byte, output frame_last,
		input ready);
	modport sink   (input valid, input event_kind, input payload_byte, input frame_last,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/magic_length_frame_deframer_top.sv =====
// a result is registered and appears in the cycle after the byte that causes it is taken
// throughput: one byte per cycle unless the output stalls; header check and body count are combinational logic
// a new byte is taken when the output register is empty or its result leaves that cycle
// reset: arst_n clears the phase, counters, output valid and sets the limit to 65536
// reset returns the block to header collection and reopens a closed link
`default_nettype none
module magic_length_frame_deframer_top
	import mlfd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [31:0] cfg_wr_data,
	mlfd_rx_if.sink     rx,
	mlfd_evt_if.source  evt
);

	phase_t               phase_q, phase_d;
	logic [HDR_CNT_W-1:0] cnt_q, cnt_d;
	logic [55:0]          hdr_q, hdr_d;
	logic [31:0]          rem_q, rem_d;
	logic [31:0]          max_q;
	logic [31:0]          len;
	logic                 accept;
	logic                 emit;
	event_kind_t          kind;
	logic [7:0]           pbyte;
	logic                 last;

	logic                 out_valid_q;
	event_kind_t          kind_q;
	logic [7:0]           pbyte_q;
	logic                 last_q;

	assign rx.ready = !out_valid_q || evt.ready;
	assign accept   = rx.valid && rx.ready;
	assign len      = {hdr_q[23:0], rx.rx_byte};

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		hdr_d   = hdr_q;
		rem_d   = rem_q;
		emit    = 1'b0;
		kind    = EV_PAYLOAD;
		pbyte   = 8'h00;
		last    = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				hdr_d = {hdr_q[47:0], rx.rx_byte};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == HDR_CNT_W'(HDR_BYTES - 1)) begin
					cnt_d = '0;
					if (hdr_q[55:48] != MAGIC_FIRST || hdr_q[47:40] != MAGIC_SECOND) begin
						emit = 1'b1;
						kind = EV_MISMATCH;
					end else if (len > max_q) begin
						emit    = 1'b1;
						kind    = EV_TOO_LARGE;
						phase_d = PH_CLOSED;
					end else if (len == 32'd0) begin
						emit = 1'b1;
						kind = EV_EMPTY;
						last = 1'b1;
					end else begin
						phase_d = PH_BODY;
						rem_d   = len;
					end
				end
			end
			PH_BODY: begin
				if (rem_q != 32'd0) begin
					rem_d = rem_q - 32'd1;
				end
				emit  = 1'b1;
				pbyte = rx.rx_byte;
				if (rem_q <= 32'd1) begin
					last    = 1'b1;
					phase_d = PH_HEADER;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q <= hdr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_BODY_RESET;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			kind_q  <= kind;
			pbyte_q <= pbyte;
			last_q  <= last;
		end
	end

	assign evt.valid        = out_valid_q;
	assign evt.event_kind   = kind_q;
	assign evt.payload_byte = pbyte_q;
	assign evt.frame_last   = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/mlfd_checker.sv =====
// port-level checks of the deframer and their binding
`default_nettype none
`include "magic_length_frame_deframer_top_assert.svh"
module mlfd_checker
	import mlfd_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       rx_ready,
	input wire       evt_valid,
	input wire       evt_ready,
	input wire [1:0] event_kind,
	input wire [7:0] payload_byte,
	input wire       frame_last
);

	`MLFD_ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable(event_kind) && $stable(payload_byte) && $stable(frame_last))
	`MLFD_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !evt_valid, rx_ready)
	`MLFD_ASSERT_NOW(a_byte_zero, clk, arst_n, evt_valid && event_kind != EV_PAYLOAD, payload_byte == 8'h00 && (frame_last == (event_kind == EV_EMPTY)))
	`MLFD_ASSERT_NEXT(a_closed_silent, clk, arst_n, evt_valid && evt_ready && event_kind == EV_TOO_LARGE, !evt_valid)

endmodule

bind magic_length_frame_deframer_top mlfd_checker u_mlfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_ready     (rx.ready),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.event_kind   (evt.event_kind),
	.payload_byte (evt.payload_byte),
	.frame_last   (evt.frame_last)
);
`default_nettype wire

// ===== tb/magic_length_frame_deframer_top_tb.sv =====
// self-checking testbench for the magic/length frame deframer
module magic_length_frame_deframer_top_tb;
	import mlfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  data;
		logic        fin;
	} deframe_evt_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	mlfd_rx_if  rx_ch ();
	mlfd_evt_if evt_ch ();

	magic_length_frame_deframer_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx_ch),
		.evt         (evt_ch)
	);

	logic [7:0]   pend_q[$];
	deframe_evt_t evt_q[$];
	int           errors;
	int           words_in;
	bit           word_taken;

	// deframer state mirror
	phase_t      ph;
	int          hdr_cnt;
	logic [63:0] hdr_shift;
	logic [31:0] body_left;
	logic [31:0] max_len;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit deframe_word(input logic [7:0] b, output deframe_evt_t ev);
		logic [31:0] len;
		bit          hit;
		ev = '{EV_PAYLOAD, 8'h00, 1'b0};
		hit = 1'b0;
		case (ph)
			PH_HEADER: begin
				hdr_shift = {hdr_shift[55:0], b};
				hdr_cnt++;
				if (hdr_cnt == HDR_BYTES) begin
					len = hdr_shift[31:0];
					hit = 1'b1;
					if (hdr_shift[63:56] != MAGIC_FIRST || hdr_shift[55:48] != MAGIC_SECOND) begin
						ev.kind = EV_MISMATCH;
					end else if (len > max_len) begin
						ev.kind = EV_TOO_LARGE;
						ph = PH_CLOSED;
					end else if (len == 32'd0) begin
						ev.kind = EV_EMPTY;
						ev.fin = 1'b1;
					end else begin
						hit = 1'b0;
						ph = PH_BODY;
						body_left = len;
					end
					hdr_cnt = 0;
					hdr_shift = '0;
				end
			end
			PH_BODY: begin
				if (body_left != 32'd0)
					body_left = body_left - 32'd1;
				hit = 1'b1;
				ev.data = b;
				ev.fin = (body_left == 32'd0);
				if (ev.fin)
					ph = PH_HEADER;
			end
			default: ;
		endcase
		return hit;
	endfunction

	always @(posedge clk) begin
		deframe_evt_t ev;
		deframe_evt_t want;
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) begin
				if (evt_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: kind %0d byte %02h last %0b",
							evt_ch.event_kind, evt_ch.payload_byte, evt_ch.frame_last);
				end else begin
					want = evt_q[0];
					evt_q.delete(0);
					if (evt_ch.event_kind !== want.kind || evt_ch.payload_byte !== want.data ||
						evt_ch.frame_last !== want.fin) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d/%02h/%0b got %0d/%02h/%0b",
								want.kind, want.data, want.fin,
								evt_ch.event_kind, evt_ch.payload_byte, evt_ch.frame_last);
					end
				end
			end
			if (rx_ch.valid && rx_ch.ready) begin
				pend_q.delete(0);
				word_taken = 1'b1;
				words_in++;
				if (deframe_word(rx_ch.rx_byte, ev))
					evt_q.insert(evt_q.size(), ev);
			end
		end
	end

	// sender: bursts with random gaps, valid held until the word is taken
	int burst_left;
	int gap_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else if (!(rx_ch.valid && !word_taken)) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				rx_ch.valid <= 1'b0;
				rx_ch.rx_byte <= 8'($urandom_range(0, 255));
			end else if (pend_q.size() > 0) begin
				rx_ch.valid <= 1'b1;
				rx_ch.rx_byte <= pend_q[0];
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off so the block backs up
	logic long_hold;
	int   hold_left;
	int   next_hold;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			long_hold <= (hold_left != 0);
		end else if (words_in >= next_hold) begin
			hold_left = 400;
			next_hold = next_hold + 600;
			long_hold <= 1'b1;
		end
	end

	// receiver stall pattern
	int pat_mode;
	int pat_left;
	int pat_tick;
	always @(negedge clk) begin
		logic rdy;
		if (pat_left == 0) begin
			pat_mode = $urandom_range(0, 3);
			pat_left = $urandom_range(20, 200);
		end
		pat_left--;
		pat_tick++;
		case (pat_mode)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			2: rdy = ($urandom_range(0, 3) == 0);
			default: rdy = pat_tick[1];
		endcase
		evt_ch.ready <= rdy && !long_hold;
	end

	task automatic settle();
		while (pend_q.size() != 0 || evt_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		max_len = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b);
		pend_q.insert(pend_q.size(), b);
	endtask

	task automatic push_header(input logic [7:0] m0, input logic [7:0] m1,
		input logic [31:0] len);
		add_byte(m0);
		add_byte(m1);
		add_byte(8'($urandom_range(0, 255)));
		add_byte(8'($urandom_range(0, 255)));
		add_byte(len[31:24]);
		add_byte(len[23:16]);
		add_byte(len[15:8]);
		add_byte(len[7:0]);
	endtask

	task automatic gen_traffic(input int budget, input logic [31:0] lim);
		int         added;
		int         cap;
		int         len;
		int         r;
		logic [7:0] b0;
		logic [7:0] b1;
		cap = (lim < 48) ? int'(lim) : 48;
		added = 0;
		while (added < budget) begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				b0 = 8'($urandom_range(0, 255));
				b1 = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 1)) begin
					if (b0 == MAGIC_FIRST)
						b0 = ~b0;
				end else begin
					b0 = MAGIC_FIRST;
					if (b1 == MAGIC_SECOND)
						b1 = ~b1;
				end
				push_header(b0, b1, $urandom());
				added += 8;
			end else begin
				r = $urandom_range(0, 7);
				if (cap == 0 || r == 0)
					len = 0;
				else if (r == 1)
					len = cap;
				else
					len = $urandom_range(1, cap);
				push_header(MAGIC_FIRST, MAGIC_SECOND, len);
				repeat (len) add_byte(8'($urandom_range(0, 255)));
				added += 8 + len;
			end
		end
	endtask

	initial begin
		logic [31:0] lim;
		errors = 0;
		words_in = 0;
		word_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		hold_left = 0;
		next_hold = 300;
		long_hold = 1'b0;
		pat_left = 0;
		pat_tick = 0;
		ph = PH_HEADER;
		hdr_cnt = 0;
		hdr_shift = '0;
		body_left = '0;
		max_len = MAX_BODY_RESET;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		evt_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// swapped magic with huge length, empty frame, two-word body
		push_header(MAGIC_SECOND, MAGIC_FIRST, 32'hFFFF_FFFF);
		push_header(MAGIC_FIRST, MAGIC_SECOND, 32'd0);
		push_header(MAGIC_FIRST, MAGIC_SECOND, 32'd2);
		add_byte(8'h00);
		add_byte(8'hFF);

		write_limit(32'd0);
		gen_traffic(250, 32'd0);
		write_limit(32'hFFFF_FFFF);
		gen_traffic(450, 32'hFFFF_FFFF);
		write_limit(MAX_BODY_RESET);
		gen_traffic(400, MAX_BODY_RESET);
		lim = $urandom_range(1, 48);
		write_limit(lim);
		gen_traffic(450, lim);
		lim = $urandom();
		write_limit(lim);
		gen_traffic(300, lim);

		// one over the limit closes the link; later frames are dropped
		lim = $urandom_range(0, 20);
		write_limit(lim);
		push_header(MAGIC_FIRST, MAGIC_SECOND, lim + 32'd1);
		push_header(MAGIC_FIRST, MAGIC_SECOND, 32'd0);
		push_header(MAGIC_FIRST, MAGIC_SECOND, 32'd3);
		repeat (3) add_byte(8'($urandom_range(0, 255)));
		settle();
		repeat (10) @(negedge clk);

		if (errors == 0 && evt_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== magic_length_frame_deframer_top.f =====
+incdir+rtl/core
rtl/core/mlfd_pkg.sv
rtl/core/mlfd_rx_if.sv
rtl/core/mlfd_evt_if.sv
rtl/core/magic_length_frame_deframer_top.sv
rtl/core/mlfd_checker.sv
tb/magic_length_frame_deframer_top_tb.sv
